/* design/x86enc_pkg.sv */
// Shared types, codes and opcode tables of the x86-64 instruction encoder.
`timescale 1ns / 1ps
package x86enc_pkg;

	localparam int NUM_SLOTS = 14;

	localparam logic [5:0] OP_FARITH_LAST = 6'd7;
	localparam logic [5:0] OP_NOOP_FIRST  = 6'd8;
	localparam logic [5:0] OP_NOOP_LAST   = 6'd39;
	localparam logic [5:0] OP_FMEM        = 6'd40;
	localparam logic [5:0] OP_ALU_FIRST   = 6'd41;
	localparam logic [5:0] OP_ALU_LAST    = 6'd48;

	localparam logic [2:0] SZ_BYTE  = 3'd0;
	localparam logic [2:0] SZ_WORD  = 3'd1;
	localparam logic [2:0] SZ_DWORD = 3'd2;
	localparam logic [2:0] SZ_QWORD = 3'd3;
	localparam logic [2:0] SZ_TBYTE = 3'd4;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_INT_REG    = 3'd1;
	localparam logic [2:0] ERR_WORD_SIZE  = 3'd2;
	localparam logic [2:0] ERR_INT_QUAD   = 3'd3;
	localparam logic [2:0] ERR_FPU_SIZE   = 3'd4;
	localparam logic [2:0] ERR_INT_TBYTE  = 3'd5;
	localparam logic [2:0] ERR_IMM_RANGE  = 3'd6;

	// byte slots in emission order
	localparam int SL_REX  = 0;
	localparam int SL_OPSZ = 1;
	localparam int SL_ADSZ = 2;
	localparam int SL_OPC  = 3;
	localparam int SL_MODR = 4;
	localparam int SL_SIB  = 5;
	localparam int SL_DISP = 6;
	localparam int SL_IMM  = 10;

	typedef struct packed {
		logic [5:0]         operation;
		logic [2:0]         fpu_flags;
		logic [2:0]         operand_size;
		logic               address_size32;
		logic               addr_mode;
		logic [3:0]         rm_reg;
		logic signed [31:0] rm_disp;
		logic [3:0]         r_reg;
		logic               has_imm;
		logic signed [31:0] imm;
		logic               rm_is_dest;
		logic               uniform_byte;
	} enc_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [2:0] error;
	} enc_out_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] bytes;
		logic [NUM_SLOTS-1:0]      mask;
		logic [2:0]                error;
	} enc_slots_t;

	function automatic logic [7:0] noop_opcode(input logic [4:0] idx);
		logic [7:0] r;
		unique case (idx) inside
			5'd28:        r = 8'hDA;
			5'd29, 5'd30: r = 8'hDB;
			5'd31:        r = 8'hDF;
			default:      r = 8'hD9;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] noop_modrm(input logic [4:0] idx);
		logic [7:0] r;
		unique case (idx)
			5'd0:    r = 8'hD0;
			5'd1:    r = 8'hE0;
			5'd2:    r = 8'hE1;
			5'd3:    r = 8'hE4;
			5'd4:    r = 8'hE5;
			5'd5:    r = 8'hE8;
			5'd6:    r = 8'hE9;
			5'd7:    r = 8'hEA;
			5'd8:    r = 8'hEB;
			5'd9:    r = 8'hEC;
			5'd10:   r = 8'hED;
			5'd11:   r = 8'hEE;
			5'd28:   r = 8'hE9;
			5'd29:   r = 8'hE2;
			5'd30:   r = 8'hE3;
			5'd31:   r = 8'hE0;
			default: r = {4'hF, idx[3:0] - 4'd12};
		endcase
		return r;
	endfunction

endpackage

/* design/x86enc_encoder.sv */
// Combinational encoding of one registered instruction description into byte slots.
`timescale 1ns / 1ps
module x86enc_encoder (
	input  x86enc_pkg::enc_in_t    cmd,
	output x86enc_pkg::enc_slots_t slots
);
	import x86enc_pkg::*;

	logic       f_int, f_pop, f_load, mem;
	logic       is_noop, is_farith, is_fmem, is_alu;
	logic       use_ext, has_op, take_imm, rex_need;
	logic [7:0] opc, modrm, rex;
	logic [2:0] ext, err, sz;
	logic [1:0] mod_bits;
	logic [5:0] alu_idx, noop_idx;
	logic       dfit8, ifit8, ifit16, disp_nz, base5;
	logic [7:0] d0, d1, d2, d3, i0, i1, i2, i3;

	assign f_int    = cmd.fpu_flags[0];
	assign f_pop    = cmd.fpu_flags[1];
	assign f_load   = cmd.fpu_flags[2];
	assign mem      = cmd.addr_mode;
	assign sz       = cmd.operand_size;
	assign is_noop  = cmd.operation >= OP_NOOP_FIRST && cmd.operation <= OP_NOOP_LAST;
	assign is_farith = cmd.operation <= OP_FARITH_LAST;
	assign is_fmem  = cmd.operation == OP_FMEM;
	assign is_alu   = cmd.operation >= OP_ALU_FIRST && cmd.operation <= OP_ALU_LAST;
	assign alu_idx  = cmd.operation - OP_ALU_FIRST;
	assign noop_idx = cmd.operation - OP_NOOP_FIRST;
	assign dfit8    = cmd.rm_disp >= -32'sd128 && cmd.rm_disp <= 32'sd127;
	assign ifit8    = cmd.imm >= -32'sd128 && cmd.imm <= 32'sd127;
	assign ifit16   = cmd.imm >= -32'sd32768 && cmd.imm <= 32'sd32767;
	assign disp_nz  = cmd.rm_disp != 32'sd0;
	assign base5    = cmd.rm_reg[2:0] == 3'd5;
	assign {d3, d2, d1, d0} = cmd.rm_disp;
	assign {i3, i2, i1, i0} = cmd.imm;

	always_comb begin
		use_ext = 1'b0;
		has_op  = 1'b1;
		opc     = 8'h00;
		ext     = 3'd0;
		err     = ERR_NONE;
		if (is_farith) begin
			use_ext = 1'b1;
			ext     = cmd.operation[2:0];
			opc     = 8'hD8 | ((f_int || f_pop) ? 8'h02 : 8'h00);
			if (f_int && !mem) begin
				err = ERR_INT_REG;
			end else if (mem) begin
				case (sz)
					SZ_WORD: begin
						if (!f_int) err = ERR_WORD_SIZE;
						opc = opc | 8'h04;
					end
					SZ_DWORD: ;
					SZ_QWORD: begin
						if (f_int) err = ERR_INT_QUAD;
						opc = opc | 8'h04;
					end
					default: err = ERR_FPU_SIZE;
				endcase
			end else if (cmd.rm_is_dest) begin
				opc = opc | 8'h04;
			end
		end else if (is_fmem) begin
			use_ext = 1'b1;
			opc     = 8'hD9 | (f_int ? 8'h02 : 8'h00);
			ext     = f_load ? 3'd0 : (f_pop ? 3'd3 : 3'd2);
			case (sz)
				SZ_DWORD: ;
				SZ_WORD: begin
					if (!f_int) err = ERR_WORD_SIZE;
					opc = opc | 8'h04;
				end
				SZ_QWORD: begin
					opc = opc | 8'h04;
					if (f_int) ext = f_load ? 3'd5 : 3'd7;
				end
				SZ_TBYTE: begin
					if (f_int) err = ERR_INT_TBYTE;
					ext = f_load ? 3'd5 : 3'd7;
				end
				default: err = ERR_FPU_SIZE;
			endcase
		end else if (is_alu) begin
			ext = alu_idx[2:0];
			opc = {2'b00, alu_idx[2:0], 3'b000};
			if (cmd.has_imm) begin
				use_ext = 1'b1;
				opc     = 8'h80 | ((sz != SZ_BYTE && ifit8) ? 8'h02 : 8'h00);
			end else if (!cmd.rm_is_dest) begin
				opc = opc | 8'h02;
			end
			if (sz != SZ_BYTE) opc = opc | 8'h01;
		end else begin
			has_op = 1'b0;
		end
	end

	assign take_imm = cmd.has_imm && (is_alu || !has_op);

	always_comb begin
		rex      = 8'h40 | {4'h0, sz == SZ_QWORD, cmd.r_reg[3], 1'b0, cmd.rm_reg[3]};
		rex_need = sz == SZ_QWORD || cmd.r_reg[3] || cmd.rm_reg[3] ||
			(sz == SZ_BYTE && cmd.uniform_byte &&
			 (cmd.r_reg[3:2] == 2'b01 || cmd.rm_reg[3:2] == 2'b01));
		if (!mem) mod_bits = 2'b11;
		else if (base5 || disp_nz) mod_bits = dfit8 ? 2'b01 : 2'b10;
		else mod_bits = 2'b00;
		modrm = {mod_bits, use_ext ? ext : cmd.r_reg[2:0], cmd.rm_reg[2:0]};
	end

	always_comb begin
		slots.bytes = '0;
		slots.mask  = '0;
		slots.error = ERR_NONE;
		if (is_noop) begin
			slots.bytes[SL_OPC]  = noop_opcode(noop_idx[4:0]);
			slots.bytes[SL_MODR] = noop_modrm(noop_idx[4:0]);
			slots.mask[SL_OPC]   = 1'b1;
			slots.mask[SL_MODR]  = 1'b1;
		end else if (err != ERR_NONE) begin
			slots.mask[0] = 1'b1;
			slots.error   = err;
		end else if (take_imm && ((sz == SZ_BYTE && !ifit8) || (sz == SZ_WORD && !ifit16))) begin
			slots.mask[0] = 1'b1;
			slots.error   = ERR_IMM_RANGE;
		end else begin
			slots.bytes[SL_REX]    = rex;
			slots.bytes[SL_OPSZ]   = 8'h66;
			slots.bytes[SL_ADSZ]   = 8'h67;
			slots.bytes[SL_OPC]    = opc;
			slots.bytes[SL_MODR]   = modrm;
			slots.bytes[SL_SIB]    = 8'h24;
			slots.bytes[SL_DISP]   = d0;
			slots.bytes[SL_DISP+1] = d1;
			slots.bytes[SL_DISP+2] = d2;
			slots.bytes[SL_DISP+3] = d3;
			slots.bytes[SL_IMM]    = i0;
			slots.bytes[SL_IMM+1]  = i1;
			slots.bytes[SL_IMM+2]  = i2;
			slots.bytes[SL_IMM+3]  = i3;
			slots.mask[SL_REX]     = rex_need;
			slots.mask[SL_OPSZ]    = sz == SZ_WORD;
			slots.mask[SL_ADSZ]    = cmd.address_size32;
			slots.mask[SL_OPC]     = has_op;
			slots.mask[SL_MODR]    = 1'b1;
			slots.mask[SL_SIB]     = mem && cmd.rm_reg[2:0] == 3'd4;
			slots.mask[SL_DISP]    = mem && (disp_nz || base5);
			slots.mask[SL_DISP+1]  = mem && (disp_nz || base5) && !dfit8;
			slots.mask[SL_DISP+2]  = mem && (disp_nz || base5) && !dfit8;
			slots.mask[SL_DISP+3]  = mem && (disp_nz || base5) && !dfit8;
			slots.mask[SL_IMM]     = take_imm;
			slots.mask[SL_IMM+1]   = take_imm && !ifit8;
			slots.mask[SL_IMM+2]   = take_imm && !ifit8 && sz != SZ_WORD;
			slots.mask[SL_IMM+3]   = take_imm && !ifit8 && sz != SZ_WORD;
		end
	end

endmodule

/* design/x86_64_instruction_encoder.sv */
// Top level of the x86-64 instruction encoder: input register, encoder and byte buffer.
// An item is taken when start is high and busy is low. It is registered, encoded into the
// byte buffer once it is empty or emitting its final byte, and its bytes then leave
// one per cycle on result, each marked by strobe for exactly one cycle, last set on the
// final byte; the receiver cannot stall them. An item yields 1 to 13 results; an invalid
// item yields one result with out_byte 0 and a nonzero error. With the buffer idle, an
// item passes the input register and the byte buffer in turn before its first byte
// is on result. The single byte output port sets the rate: an item occupies the buffer
// until its final byte has left, and a waiting item moves in during the cycle that emits
// the final byte, so bytes flow without gaps.
`timescale 1ns / 1ps
module x86_64_instruction_encoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  x86enc_pkg::enc_in_t   cmd,
	output logic                  strobe,
	output x86enc_pkg::enc_out_t  result
);
	import x86enc_pkg::*;

	enc_in_t               cmd_s1;
	logic                  vld_s1;
	enc_slots_t            slots;
	logic [NUM_SLOTS-1:0][7:0] bytes_q;
	logic [NUM_SLOTS-1:0]  mask_q;
	logic [2:0]            err_q;
	logic [NUM_SLOTS-1:0]  mask_rest;
	logic                  last_now, load, accept;
	logic [7:0]            cur_byte;

	x86enc_encoder u_enc (
		.cmd   (cmd_s1),
		.slots (slots)
	);

	assign mask_rest = mask_q & (mask_q - 1'b1);
	assign strobe    = mask_q != '0;
	assign last_now  = strobe && mask_rest == '0;
	assign load      = vld_s1 && (!strobe || last_now);
	assign busy      = vld_s1 && !load;
	assign accept    = start && !busy;

	always_comb begin
		cur_byte = 8'h00;
		for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
			if (mask_q[j]) cur_byte = bytes_q[j];
		end
	end

	assign result.out_byte = cur_byte;
	assign result.last     = last_now;
	assign result.error    = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			mask_q <= '0;
		end else begin
			if (accept) vld_s1 <= 1'b1;
			else if (load) vld_s1 <= 1'b0;
			if (load) mask_q <= slots.mask;
			else if (strobe) mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_s1 <= cmd;
		if (load) begin
			bytes_q <= slots.bytes;
			err_q   <= slots.error;
		end
	end

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> vld_s1 && strobe && !last_now)
		else $error("busy without a pending item and a draining buffer");

	a_load_emits: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> strobe)
		else $error("loaded item produced no result");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside an item's bytes");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.error != ERR_NONE |-> result.last && result.out_byte == 8'h00)
		else $error("error result is not a single zero byte");

endmodule

/* verif/x86_64_instruction_encoder_tb.sv */
// Self-checking testbench of the x86-64 instruction encoder: directed table, then random items.
`timescale 1ns / 1ps
module x86_64_instruction_encoder_tb;
	import x86enc_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 104;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] PFX_REX     = 8'h40;
	localparam logic [7:0] PFX_OPSZ    = 8'h66;
	localparam logic [7:0] PFX_ADSZ    = 8'h67;
	localparam logic [7:0] OPC_FARITH  = 8'hD8;
	localparam logic [7:0] OPC_FMEM    = 8'hD9;
	localparam logic [7:0] OPC_ALU_IMM = 8'h80;
	localparam logic [7:0] SIB_NO_IDX  = 8'h20;
	localparam logic [1:0] MOD_NODISP  = 2'b00;
	localparam logic [1:0] MOD_DISP8   = 2'b01;
	localparam logic [1:0] MOD_DISP32  = 2'b10;
	localparam logic [1:0] MOD_REG     = 2'b11;
	localparam logic [0:31][7:0] FNOARG_OPC = {{28{8'hD9}}, 8'hDA, 8'hDB, 8'hDB, 8'hDF};
	localparam logic [0:31][7:0] FNOARG_MODRM = {
		8'hD0, 8'hE0, 8'hE1, 8'hE4, 8'hE5, 8'hE8, 8'hE9, 8'hEA,
		8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hF0, 8'hF1, 8'hF2, 8'hF3,
		8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB,
		8'hFC, 8'hFD, 8'hFE, 8'hFF, 8'hE9, 8'hE2, 8'hE3, 8'hE0};

	typedef struct {
		enc_in_t    cmd;
		int         typed_n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [2:0] err;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	enc_in_t    cmd;
	logic       strobe;
	enc_out_t   result;

	int         row_typed_n;
	logic [7:0] row_b0;
	logic [7:0] row_b1;
	logic [2:0] row_err;

	enc_out_t   pending_bytes[$];
	stim_row_t  stim_table[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;

	x86_64_instruction_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("mismatch: %s", msg);
	endtask

	function automatic void expect_result(input enc_out_t r);
		pending_bytes.insert(pending_bytes.size(), r);
	endfunction

	function automatic void push_code(input logic [7:0] code_bytes[$]);
		foreach (code_bytes[k])
			expect_result(enc_out_t'{code_bytes[k], k == code_bytes.size() - 1, ERR_NONE});
	endfunction

	function automatic void predict_encoding(input enc_in_t c);
		logic [7:0] code_bytes[$];
		logic [7:0] opc;
		logic [7:0] rex;
		logic [7:0] modrm;
		logic [2:0] ext;
		logic [2:0] err;
		logic [2:0] sz;
		logic [1:0] mod_bits;
		logic       use_ext, has_op, alu, take_imm, need_rex;
		logic       f_int, f_pop, f_load, disp_short, imm_short;
		int         disp;
		int         immv;
		code_bytes = {};
		sz = c.operand_size;
		f_int = c.fpu_flags[0];
		f_pop = c.fpu_flags[1];
		f_load = c.fpu_flags[2];
		disp = c.rm_disp;
		immv = c.imm;
		disp_short = disp >= -128 && disp <= 127;
		imm_short = immv >= -128 && immv <= 127;
		err = ERR_NONE;
		use_ext = 1'b0;
		has_op = 1'b1;
		alu = 1'b0;
		opc = 8'h00;
		ext = 3'd0;

		if (c.operation >= OP_NOOP_FIRST && c.operation <= OP_NOOP_LAST) begin
			code_bytes.insert(code_bytes.size(), FNOARG_OPC[c.operation - OP_NOOP_FIRST]);
			code_bytes.insert(code_bytes.size(), FNOARG_MODRM[c.operation - OP_NOOP_FIRST]);
			push_code(code_bytes);
			return;
		end

		if (c.operation <= OP_FARITH_LAST) begin
			use_ext = 1'b1;
			ext = c.operation[2:0];
			opc = OPC_FARITH;
			if (f_int || f_pop) opc |= 8'h02;
			if (f_int && !c.addr_mode) begin
				err = ERR_INT_REG;
			end else if (c.addr_mode) begin
				case (sz)
					SZ_WORD: begin
						if (!f_int) err = ERR_WORD_SIZE;
						else opc |= 8'h04;
					end
					SZ_DWORD: ;
					SZ_QWORD: begin
						if (f_int) err = ERR_INT_QUAD;
						else opc |= 8'h04;
					end
					default: err = ERR_FPU_SIZE;
				endcase
			end else if (c.rm_is_dest) begin
				opc |= 8'h04;
			end
		end else if (c.operation == OP_FMEM) begin
			use_ext = 1'b1;
			opc = OPC_FMEM;
			if (f_int) opc |= 8'h02;
			ext = f_load ? 3'd0 : (f_pop ? 3'd3 : 3'd2);
			case (sz)
				SZ_DWORD: ;
				SZ_WORD: begin
					if (!f_int) err = ERR_WORD_SIZE;
					else opc |= 8'h04;
				end
				SZ_QWORD: begin
					opc |= 8'h04;
					if (f_int) ext = f_load ? 3'd5 : 3'd7;
				end
				SZ_TBYTE: begin
					if (f_int) err = ERR_INT_TBYTE;
					else ext = f_load ? 3'd5 : 3'd7;
				end
				default: err = ERR_FPU_SIZE;
			endcase
		end else if (c.operation >= OP_ALU_FIRST && c.operation <= OP_ALU_LAST) begin
			alu = 1'b1;
			ext = 3'(c.operation - OP_ALU_FIRST);
			opc = {2'b00, ext, 3'b000};
			if (c.has_imm) begin
				use_ext = 1'b1;
				opc = OPC_ALU_IMM;
				if (sz != SZ_BYTE && imm_short) opc |= 8'h02;
			end else if (!c.rm_is_dest) begin
				opc |= 8'h02;
			end
			if (sz != SZ_BYTE) opc |= 8'h01;
		end else begin
			has_op = 1'b0;
		end

		take_imm = c.has_imm && (alu || !has_op);
		if (err == ERR_NONE && take_imm) begin
			if (sz == SZ_BYTE && !imm_short) err = ERR_IMM_RANGE;
			if (sz == SZ_WORD && !(immv >= -32768 && immv <= 32767)) err = ERR_IMM_RANGE;
		end
		if (err != ERR_NONE) begin
			expect_result(enc_out_t'{8'h00, 1'b1, err});
			return;
		end

		rex = PFX_REX;
		need_rex = 1'b0;
		if (sz == SZ_QWORD) begin
			rex |= 8'h08;
			need_rex = 1'b1;
		end
		if (c.r_reg[3]) begin
			rex |= 8'h04;
			need_rex = 1'b1;
		end
		if (c.rm_reg[3]) begin
			rex |= 8'h01;
			need_rex = 1'b1;
		end
		// SPL..DIL need a REX even with no bit set
		if (sz == SZ_BYTE && c.uniform_byte &&
				(c.r_reg[3:2] == 2'b01 || c.rm_reg[3:2] == 2'b01))
			need_rex = 1'b1;
		if (need_rex) code_bytes.insert(code_bytes.size(), rex);
		if (sz == SZ_WORD) code_bytes.insert(code_bytes.size(), PFX_OPSZ);
		if (c.address_size32) code_bytes.insert(code_bytes.size(), PFX_ADSZ);
		if (has_op) code_bytes.insert(code_bytes.size(), opc);

		if (!c.addr_mode) mod_bits = MOD_REG;
		else if (c.rm_reg[2:0] == 3'd5 || disp != 0)
			mod_bits = disp_short ? MOD_DISP8 : MOD_DISP32;
		else mod_bits = MOD_NODISP;
		modrm = {mod_bits, use_ext ? ext : c.r_reg[2:0], c.rm_reg[2:0]};
		code_bytes.insert(code_bytes.size(), modrm);

		if (c.addr_mode) begin
			if (c.rm_reg[2:0] == 3'd4)
				code_bytes.insert(code_bytes.size(), SIB_NO_IDX | 8'h04);
			if (disp != 0 || c.rm_reg[2:0] == 3'd5) begin
				code_bytes.insert(code_bytes.size(), c.rm_disp[7:0]);
				if (!disp_short) begin
					code_bytes.insert(code_bytes.size(), c.rm_disp[15:8]);
					code_bytes.insert(code_bytes.size(), c.rm_disp[23:16]);
					code_bytes.insert(code_bytes.size(), c.rm_disp[31:24]);
				end
			end
		end

		if (take_imm) begin
			code_bytes.insert(code_bytes.size(), c.imm[7:0]);
			if (!imm_short) begin
				code_bytes.insert(code_bytes.size(), c.imm[15:8]);
				if (sz != SZ_WORD) begin
					code_bytes.insert(code_bytes.size(), c.imm[23:16]);
					code_bytes.insert(code_bytes.size(), c.imm[31:24]);
				end
			end
		end
		push_code(code_bytes);
	endfunction

	function automatic enc_in_t make_cmd(input int op, input int fl, input int sz,
			input int a32, input int mem, input int rm, input int disp, input int rr,
			input int himm, input int imm, input int dest, input int uni);
		enc_in_t c;
		c.operation = op[5:0];
		c.fpu_flags = fl[2:0];
		c.operand_size = sz[2:0];
		c.address_size32 = a32[0];
		c.addr_mode = mem[0];
		c.rm_reg = rm[3:0];
		c.rm_disp = disp;
		c.r_reg = rr[3:0];
		c.has_imm = himm[0];
		c.imm = imm;
		c.rm_is_dest = dest[0];
		c.uniform_byte = uni[0];
		return c;
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return int'($urandom_range(0, 255)) - 128;
			2: return int'($urandom_range(0, 65535)) - 32768;
			3: begin
				case ($urandom_range(0, 5))
					0: return -129;
					1: return 128;
					2: return -32769;
					3: return 32768;
					4: return int'(32'h8000_0000);
					default: return int'(32'h7FFF_FFFF);
				endcase
			end
			default: return int'($urandom);
		endcase
	endfunction

	function automatic enc_in_t random_cmd();
		enc_in_t c;
		case ($urandom_range(0, 9)) inside
			[0:1]: c.operation = 6'($urandom_range(0, OP_FARITH_LAST));
			2: c.operation = 6'($urandom_range(OP_NOOP_FIRST, OP_NOOP_LAST));
			[3:4]: c.operation = OP_FMEM;
			[5:7]: c.operation = 6'($urandom_range(OP_ALU_FIRST, OP_ALU_LAST));
			default: c.operation = 6'($urandom_range(OP_ALU_LAST + 1, 63));
		endcase
		c.fpu_flags = 3'($urandom_range(0, 7));
		c.operand_size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
			3'($urandom_range(0, 4));
		c.address_size32 = 1'($urandom_range(0, 1));
		c.addr_mode = $urandom_range(0, 99) < (c.operation <= OP_FMEM ? 80 : 50);
		c.rm_reg = 4'($urandom_range(0, 15));
		c.rm_disp = pick_value();
		c.r_reg = 4'($urandom_range(0, 15));
		c.has_imm = 1'($urandom_range(0, 1));
		c.imm = pick_value();
		c.rm_is_dest = 1'($urandom_range(0, 1));
		c.uniform_byte = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic add_row(input enc_in_t c, input int n, input logic [7:0] b0,
			input logic [7:0] b1, input logic [2:0] e);
		stim_table.insert(stim_table.size(), stim_row_t'{c, n, b0, b1, e});
	endtask

	task automatic send_item(input enc_in_t c, input int n, input logic [7:0] b0,
			input logic [7:0] b1, input logic [2:0] e, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		row_typed_n <= n;
		row_b0 <= b0;
		row_b1 <= b1;
		row_err <= e;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	// expectations are queued at the edge that takes the item
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (row_typed_n == 1) begin
				expect_result(enc_out_t'{row_b0, 1'b1, row_err});
			end else if (row_typed_n == 2) begin
				expect_result(enc_out_t'{row_b0, 1'b0, ERR_NONE});
				expect_result(enc_out_t'{row_b1, 1'b1, ERR_NONE});
			end else begin
				predict_encoding(cmd);
			end
		end
	end

	always @(posedge clk) begin
		enc_out_t want;
		if (arst_n && strobe) begin
			if (pending_bytes.size() == 0) begin
				log_mismatch($sformatf("unexpected byte %02h last %0d error %0d",
					result.out_byte, result.last, result.error));
			end else begin
				want = pending_bytes.pop_front();
				if (result.out_byte !== want.out_byte || result.last !== want.last ||
						result.error !== want.error)
					log_mismatch($sformatf(
						"expected byte %02h last %0d error %0d, got byte %02h last %0d error %0d",
						want.out_byte, want.last, want.error,
						result.out_byte, result.last, result.error));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		row_typed_n = 0;
		row_b0 = 8'h00;
		row_b1 = 8'h00;
		row_err = ERR_NONE;

		// op, flags, size, a32, mem, rm, disp, reg, has_imm, imm, dest, uniform
		add_row(make_cmd(8, 7, 7, 1, 1, 15, int'(32'h8000_0000), 15, 1, 32'h7FFF_FFFF, 1, 1),
			2, 8'hD9, 8'hD0, ERR_NONE);
		add_row(make_cmd(39, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 2, 8'hDF, 8'hE0, ERR_NONE);
		add_row(make_cmd(36, 3, 3, 0, 1, 4, 5, 9, 1, -1, 0, 0), 2, 8'hDA, 8'hE9, ERR_NONE);
		add_row(make_cmd(0, 1, 2, 0, 0, 1, 0, 2, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_INT_REG);
		add_row(make_cmd(3, 0, 1, 0, 1, 2, 0, 0, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_WORD_SIZE);
		add_row(make_cmd(5, 1, 3, 0, 1, 3, 0, 0, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_INT_QUAD);
		add_row(make_cmd(7, 0, 0, 0, 1, 6, 0, 0, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_FPU_SIZE);
		add_row(make_cmd(40, 0, 7, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_FPU_SIZE);
		add_row(make_cmd(40, 1, 4, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00, 8'h00, ERR_INT_TBYTE);
		add_row(make_cmd(41, 0, 0, 0, 0, 0, 0, 0, 1, 128, 0, 0), 1, 8'h00, 8'h00, ERR_IMM_RANGE);
		add_row(make_cmd(48, 0, 1, 0, 0, 0, 0, 0, 1, -32769, 0, 0),
			1, 8'h00, 8'h00, ERR_IMM_RANGE);
		add_row(make_cmd(49, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'hC0, 8'h00, ERR_NONE);
		add_row(make_cmd(4, 2, 0, 0, 0, 3, 0, 0, 0, 0, 1, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(1, 0, 2, 0, 1, 5, 0, 7, 0, 0, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(6, 2, 3, 1, 1, 12, -129, 3, 1, 5, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(40, 4, 4, 0, 1, 13, 127, 0, 0, 0, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(40, 3, 3, 0, 1, 4, 32'h7FFF_FFFF, 8, 0, 0, 0, 0),
			0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(40, 5, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(41, 0, 0, 0, 0, 7, 0, 4, 0, 0, 0, 1), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(42, 0, 1, 0, 1, 9, 0, 10, 1, 32767, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(43, 0, 3, 0, 0, 15, 0, 15, 1, -128, 1, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(44, 0, 2, 1, 1, 5, -128, 1, 1, int'(32'h8000_0000), 0, 0),
			0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(45, 0, 6, 0, 1, 1, 64, 2, 0, 0, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(46, 0, 0, 0, 0, 2, 0, 12, 0, 0, 1, 1), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(47, 0, 0, 0, 1, 12, 128, 5, 1, -128, 0, 1), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(48, 0, 3, 1, 1, 8, -1, 11, 0, 0, 1, 0), 0, 8'h00, 8'h00, ERR_NONE);
		add_row(make_cmd(63, 0, 2, 0, 1, 4, 0, 6, 1, 200, 0, 0), 0, 8'h00, 8'h00, ERR_NONE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_item(stim_table[i].cmd, stim_table[i].typed_n, stim_table[i].b0,
				stim_table[i].b1, stim_table[i].err, 1'b1);
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100) wait_drained();
			send_item(random_cmd(), 0, 8'h00, 8'h00, ERR_NONE, !(i >= 40 && i < 90));
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_bytes.size() != 0)
			log_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/x86enc_pkg.sv
design/x86enc_encoder.sv
design/x86_64_instruction_encoder.sv
verif/x86_64_instruction_encoder_tb.sv
